// ----- rtl/stto_pkg.sv -----
// Shared types, constants and saturation helpers for the torque observer.
`default_nettype none

package stto_pkg;

  localparam int unsigned Q_W        = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned TS_W       = 24;
  localparam int unsigned JIDX_W     = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Wide working widths: |p_hat derivative| stays below 2^50
  localparam int unsigned MAG_W = 49;
  localparam int unsigned ACC_W = 51;

  // Square root of |e| << 16: 48-bit radicand, 24-bit root, two bits a cycle
  localparam int unsigned RAD_W       = Q_W + FRAC_W;
  localparam int unsigned ROOT_W      = RAD_W / 2;
  localparam int unsigned REM_W       = ROOT_W + 3;
  localparam int unsigned SQRT_STEPS  = 2;
  localparam int unsigned SQRT_CYCLES = ROOT_W / SQRT_STEPS;
  localparam int unsigned SQ_CNT_W    = $clog2(SQRT_CYCLES + 1);

  typedef logic signed [Q_W-1:0] q1616_t;
  typedef logic [Q_W-1:0]        gain_t;
  typedef logic [TS_W-1:0]       tstep_t;
  typedef logic [JIDX_W-1:0]     jidx_t;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ROOT        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SIGN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SIGN_SCALED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LINEAR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP        = 3'd4;

  localparam gain_t  RST_GAIN_ROOT        = 32'd65536;
  localparam gain_t  RST_GAIN_SIGN        = 32'd65536;
  localparam gain_t  RST_GAIN_SIGN_SCALED = 32'd0;
  localparam gain_t  RST_GAIN_LINEAR      = 32'd0;
  localparam tstep_t RST_TIME_STEP        = 24'd83886;

  localparam logic [Q_W-1:0] Q_MAX_MAG = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN_MAG = {1'b1, {(Q_W-1){1'b0}}};

  // True when v does not fit in a signed 32-bit word
  function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-Q_W:0] hi;
    hi = v[ACC_W-1:Q_W-1];
    return !((&hi) || (~|hi));
  endfunction

  function automatic q1616_t clamp32(input logic signed [ACC_W-1:0] v);
    q1616_t r;
    if (ovf32(v)) begin
      r = v[ACC_W-1] ? q1616_t'(Q_MIN_MAG) : q1616_t'(Q_MAX_MAG);
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/stto_if.sv -----
// Valid/ready channel interfaces for step requests and observer results.
`default_nettype none

interface stto_req_if;
  import stto_pkg::*;
  logic   valid;
  logic   ready;
  logic   op;
  jidx_t  joint_index;
  q1616_t dynamics_term;
  q1616_t momentum;

  modport source (output valid, output op, output joint_index, output dynamics_term,
                  output momentum, input ready);
  modport sink   (input valid, input op, input joint_index, input dynamics_term,
                  input momentum, output ready);
endinterface

interface stto_rsp_if;
  import stto_pkg::*;
  logic   valid;
  logic   ready;
  q1616_t torque_estimate;
  q1616_t torque_rate;
  q1616_t momentum_error;
  logic   saturated;

  modport source (output valid, output torque_estimate, output torque_rate,
                  output momentum_error, output saturated, input ready);
  modport sink   (input valid, input torque_estimate, input torque_rate,
                  input momentum_error, input saturated, output ready);
endinterface

`default_nettype wire

// ----- rtl/stto_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stto_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/stto_isqrt.sv -----
// Iterative integer square root, two root bits per cycle.
`default_nettype none

module stto_isqrt
  import stto_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [SQ_CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0]    rad_q, rad_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;

  always_comb begin
    logic [REM_W-1:0]  r;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] q;
    logic [RAD_W-1:0]  x;
    r = rem_q;
    q = root_q;
    x = rad_q;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      // bring down the next two radicand bits
      r     = {r[REM_W-3:0], x[RAD_W-1:RAD_W-2]};
      x     = {x[RAD_W-3:0], 2'b00};
      trial = REM_W'({q, 2'b01});
      if (r >= trial) begin
        r = r - trial;
        q = {q[ROOT_W-2:0], 1'b1};
      end else begin
        q = {q[ROOT_W-2:0], 1'b0};
      end
    end
    rem_d  = r;
    root_d = q;
    rad_d  = x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= SQ_CNT_W'(SQRT_CYCLES);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

endmodule

`default_nettype wire

// ----- rtl/super_twisting_torque_observer.sv -----
// Sequence: a step transaction runs through the read, multiply, rate, square root wait,
// sum, time step and error states before its result is registered; a clear or
// out-of-range transaction goes straight to the result register. A step uses the square
// root unit, then the shared 32x32 multiplier and adder; a new request is taken only in idle.
// Reset: asynchronous, active low; gains return to defaults, all joint state reads as
// zero at once through per-joint valid bits, no clearing pass.
`default_nettype none

module super_twisting_torque_observer
  import stto_pkg::*;
#(
  parameter int JOINTS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  stto_req_if.sink              req_i,
  stto_rsp_if.source            rsp_o
);

  localparam int AW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int MEM_W = 3 * Q_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_MLIN  = 4'd2;
  localparam logic [3:0] S_MSCL  = 4'd3;
  localparam logic [3:0] S_RATE  = 4'd4;
  localparam logic [3:0] S_WSQ   = 4'd5;
  localparam logic [3:0] S_MROOT = 4'd6;
  localparam logic [3:0] S_PSUM1 = 4'd7;
  localparam logic [3:0] S_PSUM2 = 4'd8;
  localparam logic [3:0] S_MPD   = 4'd9;
  localparam logic [3:0] S_MRT   = 4'd10;
  localparam logic [3:0] S_TH    = 4'd11;
  localparam logic [3:0] S_EN    = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state_q, state_d;

  // configuration
  gain_t  gr_q, gn_q, gs_q, gl_q;
  tstep_t ts_q;

  // per-joint valid bits; an invalid entry reads as zero
  logic [JOINTS-1:0] vld_q;

  logic [AW-1:0] req_addr, addr_q;
  logic          acc, in_rng, vld_rd_q, do_wr_q;
  q1616_t        gam_q, p_q;

  // loaded joint state and error decode
  logic [MEM_W-1:0] ram_rdata, word;
  q1616_t           e_rd, tau_rd, ph_rd, ph_old_q, tau_q;
  logic [Q_W-1:0]   ae_rd, ae_q;
  logic             neg_q, nz_q;
  logic signed [Q_W:0] base_q;

  // shared multiplier
  logic [Q_W-1:0]   mul_a, mul_b, pmag;
  logic [2*Q_W-1:0] prod_d, prod_q;

  // shared saturating adder
  logic signed [ACC_W-1:0] add_a, add_b, add_sum, smag, tv;
  logic [Q_W-1:0]          tmag;
  logic                    tneg, add_ovf;
  q1616_t                  add_sat;

  logic [MAG_W-1:0] mag_q, rmag;
  logic             rate_ovf;
  logic [Q_W-1:0]   rate_mag_q, rate_mag_d;
  q1616_t           pdot_q, ph_q, th_q, enew_q;
  logic             sat_q;

  // square root unit
  logic              sq_start, sq_busy;
  logic [ROOT_W-1:0] sq_root;

  // result register
  logic   out_vld_q, out_load;
  q1616_t out_te_q, out_tr_q, out_me_q;
  logic   out_sat_q;

  assign req_i.ready = (state_q == S_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign req_addr    = AW'(req_i.joint_index);
  assign in_rng      = (32'(req_i.joint_index) < 32'(JOINTS));
  assign out_load    = (state_q == S_DONE) && (!out_vld_q || rsp_o.ready);

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gr_q <= RST_GAIN_ROOT;
      gn_q <= RST_GAIN_SIGN;
      gs_q <= RST_GAIN_SIGN_SCALED;
      gl_q <= RST_GAIN_LINEAR;
      ts_q <= RST_TIME_STEP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN_ROOT:        gr_q <= cfg_data_i[Q_W-1:0];
        CFG_GAIN_SIGN:        gn_q <= cfg_data_i[Q_W-1:0];
        CFG_GAIN_SIGN_SCALED: gs_q <= cfg_data_i[Q_W-1:0];
        CFG_GAIN_LINEAR:      gl_q <= cfg_data_i[Q_W-1:0];
        CFG_TIME_STEP:        ts_q <= cfg_data_i[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- joint state store
  stto_ram #(
    .WIDTH (MEM_W),
    .DEPTH (JOINTS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (out_load && do_wr_q),
    .waddr_i (addr_q),
    .wdata_i ({ph_q, th_q, enew_q}),
    .raddr_i (req_addr),
    .rdata_o (ram_rdata)
  );

  assign word   = vld_rd_q ? ram_rdata : '0;
  assign e_rd   = word[Q_W-1:0];
  assign tau_rd = word[2*Q_W-1:Q_W];
  assign ph_rd  = word[3*Q_W-1:2*Q_W];
  assign ae_rd  = e_rd[Q_W-1] ? (~e_rd + 1'b1) : e_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (acc && in_rng && (req_i.op == OP_CLEAR)) begin
      vld_q[req_addr] <= 1'b0;
    end else if (out_load && do_wr_q) begin
      vld_q[addr_q] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- square root
  assign sq_start = (state_q == S_READ);

  stto_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i ({ae_rd, {(RAD_W-Q_W){1'b0}}}),
    .busy_o     (sq_busy),
    .root_o     (sq_root)
  );

  // ---------------------------------------------------------------- shared multiplier
  assign pmag = pdot_q[Q_W-1] ? (~pdot_q + 1'b1) : pdot_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MLIN:  begin mul_a = gl_q;       mul_b = ae_q;           end
      S_MSCL:  begin mul_a = gs_q;       mul_b = ae_q;           end
      S_MROOT: begin mul_a = gr_q;       mul_b = Q_W'(sq_root);  end
      S_MPD:   begin mul_a = pmag;       mul_b = Q_W'(ts_q);     end
      S_MRT:   begin mul_a = rate_mag_q; mul_b = Q_W'(ts_q);     end
      default: ;
    endcase
  end

  assign prod_d = {{Q_W{1'b0}}, mul_a} * {{Q_W{1'b0}}, mul_b};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // ---------------------------------------------------------------- shared adder
  // time step product truncated toward zero, sign put back afterwards
  assign tmag = prod_q[TS_W+Q_W-1:TS_W];
  assign tneg = (state_q == S_MRT) ? pdot_q[Q_W-1] : neg_q;
  assign tv   = tneg ? -$signed(ACC_W'(tmag)) : $signed(ACC_W'(tmag));
  assign smag = neg_q ? -$signed(ACC_W'(mag_q)) : $signed(ACC_W'(mag_q));

  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_q)
      S_PSUM2: begin add_a = ACC_W'(base_q);   add_b = smag;                 end
      S_MRT:   begin add_a = ACC_W'(ph_old_q); add_b = tv;                   end
      S_TH:    begin add_a = ACC_W'(tau_q);    add_b = tv;                   end
      S_EN:    begin add_a = ACC_W'(p_q);      add_b = -ACC_W'(ph_q);        end
      default: ;
    endcase
  end

  assign add_sum = add_a + add_b;
  assign add_sat = clamp32(add_sum);
  assign add_ovf = ovf32(add_sum);

  // torque rate: sign of e times (gain_sign + scaled |e| term), zero for zero error
  assign rmag     = MAG_W'(gn_q) + MAG_W'(prod_q[2*Q_W-1:FRAC_W]);
  assign rate_ovf = nz_q && ((|rmag[MAG_W-1:Q_W]) ||
                             (rmag[Q_W-1] && (!neg_q || (|rmag[Q_W-2:0]))));

  always_comb begin
    if (!nz_q) begin
      rate_mag_d = '0;
    end else if (rate_ovf) begin
      rate_mag_d = neg_q ? Q_MIN_MAG : Q_MAX_MAG;
    end else begin
      rate_mag_d = rmag[Q_W-1:0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          state_d = (in_rng && (req_i.op == OP_STEP)) ? S_READ : S_DONE;
        end
      end
      S_READ:  state_d = S_MLIN;
      S_MLIN:  state_d = S_MSCL;
      S_MSCL:  state_d = S_RATE;
      S_RATE:  state_d = S_WSQ;
      S_WSQ: begin
        if (!sq_busy) begin
          state_d = S_MROOT;
        end
      end
      S_MROOT: state_d = S_PSUM1;
      S_PSUM1: state_d = S_PSUM2;
      S_PSUM2: state_d = S_MPD;
      S_MPD:   state_d = S_MRT;
      S_MRT:   state_d = S_TH;
      S_TH:    state_d = S_EN;
      S_EN:    state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      do_wr_q  <= 1'b0;
      vld_rd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc) begin
        do_wr_q  <= in_rng && (req_i.op == OP_STEP);
        vld_rd_q <= in_rng && vld_q[req_addr];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          addr_q     <= req_addr;
          gam_q      <= req_i.dynamics_term;
          p_q        <= req_i.momentum;
          // clear and out-of-range transactions report all zero
          th_q       <= '0;
          enew_q     <= '0;
          rate_mag_q <= '0;
          neg_q      <= 1'b0;
          sat_q      <= 1'b0;
        end
      end
      S_READ: begin
        ph_old_q <= ph_rd;
        tau_q    <= tau_rd;
        ae_q     <= ae_rd;
        neg_q    <= e_rd[Q_W-1];
        nz_q     <= (e_rd != '0);
        base_q   <= {gam_q[Q_W-1], gam_q} + {tau_rd[Q_W-1], tau_rd};
      end
      S_MSCL: mag_q <= MAG_W'(prod_q[2*Q_W-1:FRAC_W]);
      S_RATE: begin
        rate_mag_q <= rate_mag_d;
        sat_q      <= sat_q | rate_ovf;
      end
      S_PSUM1: mag_q <= mag_q + MAG_W'(prod_q[Q_W+ROOT_W-1:FRAC_W]);
      S_PSUM2: begin
        pdot_q <= add_sat;
        sat_q  <= sat_q | add_ovf;
      end
      S_MRT: begin
        ph_q  <= add_sat;
        sat_q <= sat_q | add_ovf;
      end
      S_TH: begin
        th_q  <= add_sat;
        sat_q <= sat_q | add_ovf;
      end
      S_EN: begin
        enew_q <= add_sat;
        sat_q  <= sat_q | add_ovf;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_te_q  <= th_q;
      out_tr_q  <= neg_q ? q1616_t'(~rate_mag_q + 1'b1) : q1616_t'(rate_mag_q);
      out_me_q  <= enew_q;
      out_sat_q <= sat_q;
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.torque_estimate = out_te_q;
  assign rsp_o.torque_rate     = out_tr_q;
  assign rsp_o.momentum_error  = out_me_q;
  assign rsp_o.saturated       = out_sat_q;

  // ---------------------------------------------------------------- assertions
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q) == S_DONE)
    else $error("result raised outside the completion state");

  a_sqrt_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_busy |-> (state_q != S_IDLE && state_q != S_READ && state_q != S_DONE))
    else $error("square root unit busy outside a step");

  a_clear_drops_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_rng && req_i.op == OP_CLEAR) |=> !vld_q[addr_q])
    else $error("cleared joint still marked valid");

  a_zero_error_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WSQ && !nz_q) |-> rate_mag_q == '0)
    else $error("non-zero torque rate for zero momentum error");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the per-joint super-twisting torque observer.
`timescale 1ns / 1ps

module tb;
  import stto_pkg::*;

  localparam int          NUM_JOINTS       = 64;
  localparam int          RANDOM_PER_PHASE = 335;
  localparam int          NUM_PHASES       = 6;
  localparam int          HOLD_CYCLES      = 400;
  localparam int          SETTLE_CYCLES    = 40;
  localparam int unsigned CYCLE_LIMIT      = 1000000;
  localparam int          REPORT_LIMIT     = 10;

  localparam q1616_t Q_LO = 32'sh8000_0000;
  localparam q1616_t Q_HI = 32'sh7FFF_FFFF;
  localparam longint SAT_HI = (64'sd1 <<< 31) - 64'sd1;
  localparam longint SAT_LO = -(64'sd1 <<< 31);

  typedef struct packed {
    q1616_t torque_estimate;
    q1616_t torque_rate;
    q1616_t momentum_error;
    logic   saturated;
  } obs_result_t;

  // Observer state per joint, the gain set and the queue of expected results
  class torque_scoreboard;
    longint unsigned g_root, g_sign, g_sign_scl, g_lin, t_step;
    longint          p_hat   [NUM_JOINTS];
    longint          tau_hat [NUM_JOINTS];
    longint          err_mem [NUM_JOINTS];
    obs_result_t     expected_obs [$];
    int unsigned     n_steps, n_clears, n_checked, n_sat, n_err;
    bit              sat_hit;

    function new();
      g_root     = RST_GAIN_ROOT;
      g_sign     = RST_GAIN_SIGN;
      g_sign_scl = RST_GAIN_SIGN_SCALED;
      g_lin      = RST_GAIN_LINEAR;
      t_step     = RST_TIME_STEP;
      foreach (p_hat[i]) begin
        p_hat[i]   = 0;
        tau_hat[i] = 0;
        err_mem[i] = 0;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN_ROOT:        g_root     = data;
        CFG_GAIN_SIGN:        g_sign     = data;
        CFG_GAIN_SIGN_SCALED: g_sign_scl = data;
        CFG_GAIN_LINEAR:      g_lin      = data;
        CFG_TIME_STEP:        t_step     = data[TS_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > SAT_HI) begin
        sat_hit = 1'b1;
        return SAT_HI;
      end
      if (v < SAT_LO) begin
        sat_hit = 1'b1;
        return SAT_LO;
      end
      return v;
    endfunction

    function longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    // Scale on the magnitude so the product truncates towards zero
    function longint scale_trunc(longint a, longint unsigned b, int sh);
      longint unsigned m;
      m = (magnitude(a) * b) >> sh;
      return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    function longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r, c;
      r = 0;
      for (int b = 24; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= x) r = c;
      end
      return r;
    endfunction

    // Advance one joint's observer and queue the result it must produce
    function void advance_joint(logic op, jidx_t j, q1616_t gam, q1616_t mom);
      longint          e, tau0, sgn, pdot, rate, ph, th, enew;
      longint unsigned ae, root;
      obs_result_t     r;
      r = '0;
      if (op == OP_CLEAR) begin
        p_hat[j]   = 0;
        tau_hat[j] = 0;
        err_mem[j] = 0;
        n_clears++;
        expected_obs.push_back(r);
        return;
      end
      n_steps++;
      sat_hit = 1'b0;
      e    = err_mem[j];
      tau0 = tau_hat[j];
      ae   = magnitude(e);
      sgn  = (e < 0) ? -64'sd1 : ((e > 0) ? 64'sd1 : 64'sd0);
      root = floor_sqrt(ae << 16);
      pdot = longint'(gam) + tau0
           + sgn * longint'((g_root * root) >> 16)
           + sgn * longint'((g_lin * ae) >> 16);
      pdot = clip32(pdot);
      if (e == 0) rate = 0;
      else rate = clip32(sgn * longint'(g_sign + ((g_sign_scl * ae) >> 16)));
      ph   = clip32(p_hat[j] + scale_trunc(pdot, t_step, 24));
      th   = clip32(tau0 + scale_trunc(rate, t_step, 24));
      enew = clip32(longint'(mom) - ph);
      p_hat[j]   = ph;
      tau_hat[j] = th;
      err_mem[j] = enew;
      r.torque_estimate = q1616_t'(th);
      r.torque_rate     = q1616_t'(rate);
      r.momentum_error  = q1616_t'(enew);
      r.saturated       = sat_hit;
      expected_obs.push_back(r);
    endfunction

    function void check_result(obs_result_t act);
      obs_result_t want;
      if (expected_obs.size() == 0) begin
        n_err++;
        if (n_err <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding: tau %h rate %h err %h sat %b",
                   $time, act.torque_estimate, act.torque_rate, act.momentum_error,
                   act.saturated);
        return;
      end
      want = expected_obs.pop_front();
      n_checked++;
      if (act.saturated) n_sat++;
      if (act.torque_estimate !== want.torque_estimate ||
          act.torque_rate !== want.torque_rate ||
          act.momentum_error !== want.momentum_error ||
          act.saturated !== want.saturated) begin
        n_err++;
        if (n_err <= REPORT_LIMIT)
          $display("%0t: result %0d mismatch: tau %h/%h rate %h/%h err %h/%h sat %b/%b",
                   $time, n_checked, want.torque_estimate, act.torque_estimate,
                   want.torque_rate, act.torque_rate, want.momentum_error,
                   act.momentum_error, want.saturated, act.saturated);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  rx_hold = 1'b0;
  bit                    hold_arm = 1'b0;
  int unsigned           send_idle_pct = 29;
  int unsigned           recv_idle_pct = 59;
  int unsigned           cycle_cnt = 0;

  torque_scoreboard obs = new();

  stto_req_if req_if ();
  stto_rsp_if rsp_if ();

  super_twisting_torque_observer #(.JOINTS(NUM_JOINTS)) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random back-pressure, blocked entirely during a hold
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    wait (hold_arm);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rsp_if.valid && rsp_if.ready)
      obs.check_result('{rsp_if.torque_estimate, rsp_if.torque_rate,
                         rsp_if.momentum_error, rsp_if.saturated});
    if (req_if.valid && req_if.ready)
      obs.advance_joint(req_if.op, req_if.joint_index, req_if.dynamics_term,
                        req_if.momentum);
  end

  task automatic send_item(input logic op, input jidx_t j, input q1616_t gam,
                           input q1616_t mom);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.op            <= op;
    req_if.joint_index   <= j;
    req_if.dynamics_term <= gam;
    req_if.momentum      <= mom;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Stop offering, wait for every outstanding result, then let the pipeline settle
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (obs.expected_obs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    obs.set_register(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gains(input gain_t gr, input gain_t gs, input gain_t gss,
                           input gain_t gl, input tstep_t ts);
    write_reg(CFG_GAIN_ROOT, gr);
    write_reg(CFG_GAIN_SIGN, gs);
    write_reg(CFG_GAIN_SIGN_SCALED, gss);
    write_reg(CFG_GAIN_LINEAR, gl);
    write_reg(CFG_TIME_STEP, CFG_DATA_W'(ts));
  endtask

  function automatic q1616_t pick_extreme();
    case ($urandom_range(4))
      0:       return Q_LO;
      1:       return Q_HI;
      2:       return 32'sd0;
      3:       return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  // Mostly repeated steps on a few joints with moderate values, so the
  // observers build up state; the rest is full-range noise, extremes and clears
  task automatic send_random(input int n);
    int unsigned kind;
    logic        op;
    jidx_t       j;
    q1616_t      gam, mom;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(99);
      op   = (kind < 6) ? OP_CLEAR : OP_STEP;
      j    = ($urandom_range(3) != 0) ? jidx_t'($urandom_range(7))
                                      : jidx_t'($urandom_range(NUM_JOINTS - 1));
      if (kind < 70) begin
        gam = q1616_t'(int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
        mom = q1616_t'(int'($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
      end else if (kind < 90) begin
        gam = q1616_t'($urandom);
        mom = q1616_t'($urandom);
      end else begin
        gam = pick_extreme();
        mom = pick_extreme();
      end
      send_item(op, j, gam, mom);
    end
  endtask

  initial begin
    int unsigned n_settings;
    n_settings           = 1;
    req_if.valid         <= 1'b0;
    req_if.op            <= OP_STEP;
    req_if.joint_index   <= '0;
    req_if.dynamics_term <= '0;
    req_if.momentum      <= '0;
    cfg_we               <= 1'b0;
    cfg_idx              <= CFG_GAIN_ROOT;
    cfg_data             <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero error first, then a growing error, clears and extremes
    send_item(OP_STEP,  6'd0,  32'sd0,       32'sd0);
    send_item(OP_STEP,  6'd0,  32'sh1_0000,  32'sh2_0000);
    send_item(OP_STEP,  6'd0,  32'sh1_0000,  32'sh2_0000);
    send_item(OP_STEP,  6'd0,  -32'sh3_0000, -32'sh5_0000);
    send_item(OP_STEP,  6'd0,  32'sd0,       -32'sh5_0000);
    send_item(OP_CLEAR, 6'd0,  Q_HI,         Q_LO);
    send_item(OP_STEP,  6'd0,  32'sd0,       32'sd0);
    send_item(OP_STEP,  6'd63, Q_HI,         Q_LO);
    send_item(OP_STEP,  6'd63, Q_HI,         Q_HI);
    send_item(OP_STEP,  6'd63, Q_LO,         Q_HI);
    send_item(OP_STEP,  6'd63, Q_LO,         Q_LO);
    send_item(OP_STEP,  6'd63, Q_LO,         Q_LO);
    send_item(OP_CLEAR, 6'd63, 32'sd0,       32'sd0);
    send_item(OP_STEP,  6'd63, 32'sd0,       32'sd1);
    send_item(OP_STEP,  6'd1,  -32'sd1,      32'sd1);
    send_item(OP_STEP,  6'd1,  32'sd1,       -32'sd1);
    send_item(OP_STEP,  6'd1,  32'sd0,       32'sd0);
    send_item(OP_STEP,  6'd1,  Q_LO,         Q_LO);
    send_item(OP_STEP,  6'd1,  Q_LO,         Q_LO);
    send_item(OP_STEP,  6'd1,  Q_HI,         Q_LO);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0, 1: begin send_idle_pct = 29; recv_idle_pct = 59; end
        2, 3: begin send_idle_pct = 59; recv_idle_pct = 29; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: set_gains(gain_t'($urandom_range(32'h4_0000)), gain_t'($urandom_range(32'h8_0000)),
                     gain_t'($urandom_range(32'h2_0000)), gain_t'($urandom_range(32'h4_0000)),
                     tstep_t'($urandom_range(200000, 1000)));
        1: set_gains('1, '1, '1, '1, '1);
        2: set_gains('0, '0, '0, '0, '0);
        3: set_gains(gain_t'($urandom), gain_t'($urandom), gain_t'($urandom),
                     gain_t'($urandom), tstep_t'($urandom));
        4: set_gains(gain_t'($urandom_range(32'h2_0000)), gain_t'($urandom_range(32'h4_0000)),
                     gain_t'($urandom_range(32'h1_0000)), gain_t'($urandom_range(32'h2_0000)),
                     tstep_t'($urandom_range(100000, 1)));
        default: set_gains('0, '1, '0, '1, tstep_t'(1));
      endcase
      n_settings++;
      // Block the result side for a long stretch while requests keep coming
      if (ph == 0) hold_arm = 1'b1;
      send_random(RANDOM_PER_PHASE);
      drain();
    end

    $display("Covered %0d steps and %0d clears over %0d gain settings.",
             obs.n_steps, obs.n_clears, n_settings);
    $display("Checked %0d results, %0d of them saturated; %0d mismatches.",
             obs.n_checked, obs.n_sat, obs.n_err);
    if (obs.n_err == 0 && obs.expected_obs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
